### hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int WORD_W      = 32;
  localparam int SYM_W       = 8;
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int STEP_W      = $clog2(WORD_W);

  localparam logic [SYM_W-1:0]  SYM_MUL    = 8'h2A;  // '*'
  localparam logic [SYM_W-1:0]  SYM_ADD    = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0]  SYM_SUB    = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0]  SYM_DIV    = 8'h2F;  // '/'
  localparam logic [WORD_W-1:0] DIGIT_BIAS = 32'd48;

  // error flag bit positions
  localparam int FLAG_OV = 0;
  localparam int FLAG_UF = 1;
  localparam int FLAG_DZ = 2;
  localparam int FLAG_W  = 3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } pfe_opc_t;

  typedef struct packed {
    pfe_opc_t          op;
    logic [WORD_W-1:0] operand;
    logic              last;
  } pfe_op_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } pfe_md_req_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_POP_R,
    B_CAP_R,
    B_POP_L,
    B_CAP_L,
    B_EXEC,
    B_WAIT,
    B_PUSH,
    B_FIN_POP,
    B_FIN_CAP,
    B_EMIT
  } pfe_bstate_t;

endpackage

### hdl/pfe_in_if.sv
// ----------------------------------------------------------------------------
// pfe_in_if
// Input channel: one expression character per item.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

### hdl/pfe_out_if.sv
// ----------------------------------------------------------------------------
// pfe_out_if
// Result channel: final value and sticky error flags.
// ----------------------------------------------------------------------------
interface pfe_out_if;
  import pfe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value;
  logic                     overflow_seen;
  logic                     underflow_seen;
  logic                     divide_by_zero_seen;

  modport source (output valid, output value, output overflow_seen, output underflow_seen,
                  output divide_by_zero_seen, input ready);
  modport sink   (input valid, input value, input overflow_seen, input underflow_seen,
                  input divide_by_zero_seen, output ready);
endinterface

### hdl/postfix_expression_evaluator.sv
// A digit item is taken from the queue in B_IDLE and pushed in B_PUSH; + and -
// pop both operands first; * and / use the 32-step shift-add/subtract unit.
// The two-entry queue takes characters while an item executes; the end of an
// expression adds a final pop, via the registered stack RAM read, before output.
// Reset (rst, synchronous) empties the queue, the stack count and the flags;
// the stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Character-serial postfix evaluator with a 16-entry signed 32-bit stack.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
  input  logic       clk,
  input  logic       rst,
  pfe_in_if.sink     symbols,
  pfe_out_if.source  results
);
  import pfe_pkg::*;

  logic              q_valid;
  pfe_op_t           q_entry;
  logic              q_pop;
  pfe_md_req_t       md_req;
  logic              md_done;
  logic [WORD_W-1:0] md_result;

  pfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  pfe_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .md_req    (md_req),
    .md_done   (md_done),
    .md_result (md_result),
    .results   (results)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !symbols.ready |-> q_valid)
    else $error("input stalled with queue not full");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (md_req.start && md_req.is_div) |-> (md_req.b != '0))
    else $error("divider started with zero divisor");

  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    md_req.start |=> !md_done)
    else $error("multiply/divide finished in one cycle");

endmodule

### hdl/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts characters, decodes them into stack operations and queues them.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic            clk,
  input  logic            rst,
  pfe_in_if.sink          symbols,
  output logic            q_valid,
  output pfe_pkg::pfe_op_t q_entry,
  input  logic            q_pop
);
  import pfe_pkg::*;

  pfe_op_t             q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   q_cnt;
  pfe_op_t             dec;
  logic                push;

  always_comb begin
    dec.last    = symbols.end_of_expression;
    dec.operand = {{(WORD_W-SYM_W){1'b0}}, symbols.symbol} - DIGIT_BIAS;
    case (symbols.symbol)
      SYM_MUL: dec.op = OP_MUL;
      SYM_DIV: dec.op = OP_DIV;
      SYM_ADD: dec.op = OP_ADD;
      SYM_SUB: dec.op = OP_SUB;
      default: dec.op = OP_PUSH;
    endcase
  end

  assign symbols.ready = (q_cnt != QCNT_W'(QDEPTH));
  assign push          = symbols.valid && symbols.ready;
  assign q_valid       = (q_cnt != '0);
  assign q_entry       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   q_cnt <= q_cnt + 1'b1;
        2'b01:   q_cnt <= q_cnt - 1'b1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

endmodule

### hdl/pfe_muldiv.sv
// ----------------------------------------------------------------------------
// pfe_muldiv
// Iterative 32-step multiplier (low word) and signed truncating divider.
// ----------------------------------------------------------------------------
module pfe_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  pfe_pkg::pfe_md_req_t          req,
  output logic                          done,
  output logic [pfe_pkg::WORD_W-1:0]    result
);
  import pfe_pkg::*;

  logic              busy;
  logic              is_div;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [WORD_W:0]   acc;     // product, or remainder for divide
  logic [WORD_W-1:0] mcand;   // multiplicand, or divisor magnitude
  logic [WORD_W-1:0] mplier;  // multiplier, or dividend/quotient
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] a_mag;
  logic [WORD_W-1:0] b_mag;

  assign a_mag  = req.a[WORD_W-1] ? -req.a : req.a;
  assign b_mag  = req.b[WORD_W-1] ? -req.b : req.b;
  assign rem_sh = {acc[WORD_W-1:0], mplier[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, mcand};
  assign result = is_div ? (neg ? -mplier : mplier) : acc[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      neg    <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
      acc    <= '0;
      mcand  <= req.is_div ? b_mag : req.a;
      mplier <= req.is_div ? a_mag : req.b;
    end else if (busy) begin
      if (is_div) begin
        // restoring step: one quotient bit per cycle
        if (!diff[WORD_W]) begin
          acc    <= diff;
          mplier <= {mplier[WORD_W-2:0], 1'b1};
        end else begin
          acc    <= rem_sh;
          mplier <= {mplier[WORD_W-2:0], 1'b0};
        end
      end else begin
        if (mplier[0]) begin
          acc <= {1'b0, acc[WORD_W-1:0] + mcand};
        end
        mcand  <= {mcand[WORD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[WORD_W-1:1]};
      end
    end
  end

endmodule

### hdl/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Executes queued operations on the operand stack and emits the final result.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  pfe_pkg::pfe_op_t           q_entry,
  output logic                       q_pop,
  output pfe_pkg::pfe_md_req_t       md_req,
  input  logic                       md_done,
  input  logic [pfe_pkg::WORD_W-1:0] md_result,
  pfe_out_if.source                  results
);
  import pfe_pkg::*;

  pfe_bstate_t       state;
  pfe_bstate_t       state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_dec;
  logic [FLAG_W-1:0] flags;
  pfe_op_t           cur;
  logic [WORD_W-1:0] rhs;
  logic [WORD_W-1:0] lhs;
  logic [WORD_W-1:0] res;
  logic              out_valid;
  logic              out_free;
  logic              empty;
  logic              full;

  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;

  assign cnt_dec  = cnt - 1'b1;
  assign empty    = (cnt == '0);
  assign full     = (cnt == CNT_W'(STACK_DEPTH));
  assign out_free = !out_valid || results.ready;
  assign rd_addr  = cnt_dec[PTR_W-1:0];

  pfe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt[PTR_W-1:0]),
    .wdata (res),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:    if (q_valid) begin
                   state_next = (q_entry.op == OP_PUSH) ? B_PUSH : B_POP_R;
                 end
      B_POP_R:   state_next = empty ? B_POP_L : B_CAP_R;
      B_CAP_R:   state_next = B_POP_L;
      B_POP_L:   state_next = empty ? B_EXEC : B_CAP_L;
      B_CAP_L:   state_next = B_EXEC;
      B_EXEC:    state_next = md_req.start ? B_WAIT : B_PUSH;
      B_WAIT:    if (md_done) begin
                   state_next = B_PUSH;
                 end
      B_PUSH:    state_next = cur.last ? B_FIN_POP : B_IDLE;
      B_FIN_POP: state_next = empty ? B_EMIT : B_FIN_CAP;
      B_FIN_CAP: state_next = B_EMIT;
      B_EMIT:    if (out_free) begin
                   state_next = B_IDLE;
                 end
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = (state == B_IDLE) && q_valid;
    rd_en         = !empty && ((state == B_POP_R) || (state == B_POP_L) ||
                               (state == B_FIN_POP));
    wr_en         = (state == B_PUSH) && !full;
    md_req.start  = (state == B_EXEC) &&
                    ((cur.op == OP_MUL) || ((cur.op == OP_DIV) && (rhs != '0)));
    md_req.is_div = (cur.op == OP_DIV);
    md_req.a      = lhs;
    md_req.b      = rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == B_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_POP_R, B_POP_L, B_FIN_POP: begin
          if (empty) begin
            flags[FLAG_UF] <= 1'b1;
          end else begin
            cnt <= cnt_dec;
          end
        end
        B_EXEC: begin
          if ((cur.op == OP_DIV) && (rhs == '0)) begin
            flags[FLAG_DZ] <= 1'b1;
          end
        end
        B_PUSH: begin
          if (full) begin
            flags[FLAG_OV] <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            cnt   <= '0;
            flags <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          cur <= q_entry;
          res <= q_entry.operand;
        end
      end
      B_POP_R:   if (empty) begin
                   rhs <= '0;
                 end
      B_CAP_R:   rhs <= rd_data;
      B_POP_L:   if (empty) begin
                   lhs <= '0;
                 end
      B_CAP_L:   lhs <= rd_data;
      B_EXEC: begin
        case (cur.op)
          OP_ADD:  res <= lhs + rhs;
          OP_SUB:  res <= lhs - rhs;
          default: res <= '0;  // divide by zero pushes zero; others overwritten
        endcase
      end
      B_WAIT:    if (md_done) begin
                   res <= md_result;
                 end
      B_FIN_POP: if (empty) begin
                   res <= '0;
                 end
      B_FIN_CAP: res <= rd_data;
      B_EMIT: begin
        if (out_free) begin
          results.value               <= res;
          results.overflow_seen       <= flags[FLAG_OV];
          results.underflow_seen      <= flags[FLAG_UF];
          results.divide_by_zero_seen <= flags[FLAG_DZ];
        end
      end
      default: ;
    endcase
  end

  assign results.valid = out_valid;

endmodule

### verif/postfix_expression_evaluator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Drives character streams into the evaluator and scores every result. An
// in-bench stack evaluator predicts each value and its error flags. Directed
// cases cover the corners; random well-formed expressions and noise follow.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;
  import pfe_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     overflow_seen;
    logic                     underflow_seen;
    logic                     divide_by_zero_seen;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfe_in_if  sym_ch ();
  pfe_out_if res_ch ();

  postfix_expression_evaluator dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .results (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // evaluator state kept by the bench
  logic [WORD_W-1:0] operand_stack [STACK_DEPTH];
  int unsigned       stack_used;
  logic [FLAG_W-1:0] sticky_flags;

  eval_result_t pending_answers [$];
  eval_result_t awaited;
  int           error_count = 0;
  int           sent_count  = 0;
  bit           gaps_on     = 1'b1;
  int           stall_left  = 0;

  function automatic void push_operand(logic [WORD_W-1:0] v);
    if (stack_used >= STACK_DEPTH) begin
      sticky_flags[FLAG_OV] = 1'b1;
    end else begin
      operand_stack[stack_used] = v;
      stack_used++;
    end
  endfunction

  function automatic logic [WORD_W-1:0] pop_operand();
    if (stack_used == 0) begin
      sticky_flags[FLAG_UF] = 1'b1;
      return '0;
    end
    stack_used--;
    return operand_stack[stack_used];
  endfunction

  // magnitude divide, sign fixed up after; MIN / -1 wraps to MIN
  function automatic logic [WORD_W-1:0] quotient_toward_zero(logic [WORD_W-1:0] a,
                                                             logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] q;
    mag_a = a[WORD_W-1] ? -a : a;
    mag_b = b[WORD_W-1] ? -b : b;
    q = mag_a / mag_b;
    return (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
  endfunction

  function automatic void apply_symbol(logic [SYM_W-1:0] sym, logic last);
    logic [WORD_W-1:0] rhs;
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] res;
    eval_result_t      answer;
    if (sym == SYM_MUL || sym == SYM_DIV || sym == SYM_ADD || sym == SYM_SUB) begin
      rhs = pop_operand();
      lhs = pop_operand();
      if (sym == SYM_MUL) begin
        res = lhs * rhs;
      end else if (sym == SYM_DIV) begin
        if (rhs == '0) begin
          sticky_flags[FLAG_DZ] = 1'b1;
          res = '0;
        end else begin
          res = quotient_toward_zero(lhs, rhs);
        end
      end else if (sym == SYM_ADD) begin
        res = lhs + rhs;
      end else begin
        res = lhs - rhs;
      end
      push_operand(res);
    end else begin
      push_operand(WORD_W'(sym) - DIGIT_BIAS);
    end
    if (last) begin
      answer.value               = pop_operand();
      answer.overflow_seen       = sticky_flags[FLAG_OV];
      answer.underflow_seen      = sticky_flags[FLAG_UF];
      answer.divide_by_zero_seen = sticky_flags[FLAG_DZ];
      pending_answers.push_back(answer);
      stack_used   = 0;
      sticky_flags = '0;
    end
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sym_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sym_ch.valid             <= 1'b1;
    sym_ch.symbol            <= sym;
    sym_ch.end_of_expression <= last;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    apply_symbol(sym, last);
    sent_count++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_for_drain();
    sym_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_MUL;
      1:       return SYM_DIV;
      2:       return SYM_ADD;
      default: return SYM_SUB;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] random_operand();
    logic [SYM_W-1:0] sym;
    if ($urandom_range(0, 3) != 0) return SYM_W'("0") + SYM_W'($urandom_range(0, 9));
    do begin
      sym = SYM_W'($urandom_range(0, 255));
    end while (sym == SYM_MUL || sym == SYM_DIV || sym == SYM_ADD || sym == SYM_SUB);
    return sym;
  endfunction

  task automatic send_sequence(input logic [SYM_W-1:0] seq [$]);
    foreach (seq[i]) send_symbol(seq[i], i == seq.size() - 1);
  endtask

  // well-formed postfix; a high cap piles operands past the stack size
  task automatic send_random_expression();
    logic [SYM_W-1:0] body [$];
    int ops_left;
    int operands_left;
    int depth;
    int cap;
    ops_left      = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
    operands_left = ops_left + 1;
    cap           = ($urandom_range(0, 7) == 0) ? STACK_DEPTH + 2 : $urandom_range(2, 5);
    depth         = 0;
    while (ops_left + operands_left > 0) begin
      if (depth >= 2 && ops_left > 0 &&
          (operands_left == 0 || depth >= cap ||
           (cap <= 5 && $urandom_range(0, 1) == 1))) begin
        body.push_back(random_operator());
        ops_left--;
        depth--;
      end else begin
        body.push_back(random_operand());
        operands_left--;
        depth++;
      end
    end
    send_sequence(body);
  endtask

  task automatic test_wrapping_divide();
    logic [SYM_W-1:0] seq [$];
    // 128^4 * 8 = 2^31 wraps to the most negative value, then divide by 0 - 1
    seq = '{8'hB0, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, 8'hB0, SYM_MUL, "8", SYM_MUL,
            "0", "1", SYM_SUB, SYM_DIV};
    send_sequence(seq);
  endtask

  task automatic test_error_flags();
    logic [SYM_W-1:0] seq [$];
    seq = '{"5", "0", SYM_DIV};
    send_sequence(seq);
    // lone operator on an empty stack
    send_symbol(SYM_ADD, 1'b1);
  endtask

  task automatic test_stack_full();
    logic [SYM_W-1:0] seq [$];
    seq = '{8'h00, 8'hFF, "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
            8'h7F, 8'h80, 8'h01, "9", "3"};
    send_sequence(seq);
  endtask

  task automatic test_random_mix(input int n);
    int stop_at;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 5))
          send_symbol(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        send_random_expression();
      end
    end
  endtask

  // result side: random stall bursts, scoring on every handshake
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result: value %0d", res_ch.value);
          error_count++;
        end else begin
          awaited = pending_answers.pop_front();
          if (res_ch.value !== awaited.value) begin
            $error("value: expected %0d, got %0d", awaited.value, res_ch.value);
            error_count++;
          end
          if (res_ch.overflow_seen !== awaited.overflow_seen) begin
            $error("overflow_seen: expected %0b, got %0b",
                   awaited.overflow_seen, res_ch.overflow_seen);
            error_count++;
          end
          if (res_ch.underflow_seen !== awaited.underflow_seen) begin
            $error("underflow_seen: expected %0b, got %0b",
                   awaited.underflow_seen, res_ch.underflow_seen);
            error_count++;
          end
          if (res_ch.divide_by_zero_seen !== awaited.divide_by_zero_seen) begin
            $error("divide_by_zero_seen: expected %0b, got %0b",
                   awaited.divide_by_zero_seen, res_ch.divide_by_zero_seen);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    sym_ch.valid             = 1'b0;
    sym_ch.symbol            = '0;
    sym_ch.end_of_expression = 1'b0;
    stack_used               = 0;
    sticky_flags             = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_wrapping_divide();
    test_error_flags();
    test_stack_full();
    test_random_mix(900);
    wait_for_drain();
    test_random_mix(700);
    gaps_on = 1'b0;
    test_random_mix(300);
    wait_for_drain();
    repeat (60) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
